### rtl/core/plp_pkg.sv
// shared widths, latencies and helper types for the point-line projection core
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package plp_pkg;

	localparam int CW      = 32;            // coordinate width, q24.8
	localparam int DW      = CW + 1;        // difference of two coordinates
	localparam int MW      = CW;            // magnitude of a difference
	localparam int PW      = 2 * MW;        // product of two magnitudes
	localparam int LW      = PW + 1;        // dot product magnitude and squared length
	localparam int QUO_W   = 34;            // quotient bits, |AD| component stays below 2^34
	localparam int NUM_W   = 99;            // 2*dot*|ab| + l2
	localparam int DSOR_W  = LW + 1;        // 2*l2
	localparam int REM_W   = DSOR_W + 1;    // partial remainder with the shifted-in bit
	localparam int ADW     = QUO_W + 1;     // signed AD component
	localparam int FW      = ADW + 1;       // unsaturated foot coordinate
	localparam int EW      = FW + 1;        // P minus foot, also the sqrt input width
	localparam int LEN_W   = 31;            // saturated length
	localparam int SQ_ITER = 32;            // sqrt steps, one result bit each
	localparam int SQ_R_W  = 64;            // sqrt root and remainder width

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [CW-1:0]    POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0]    NEG_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam int FRONT_LAT = 5;
	localparam int DIV_LAT   = QUO_W;
	localparam int POST_LAT  = 2;
	localparam int SQ_LAT    = SQ_ITER + 3;
	localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + POST_LAT + SQ_LAT;

	// item fields that ride alongside the divider
	typedef struct packed {
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic          dneg;
		logic          negx;
		logic          negy;
		logic          deg;
	} side_t;

	// front end output: dividends, divisor and the side fields
	typedef struct packed {
		logic [NUM_W-1:0]  num_x;
		logic [NUM_W-1:0]  num_y;
		logic [DSOR_W-1:0] dsor;
		side_t             side;
	} front_t;

	// item fields that ride alongside the square root units
	typedef struct packed {
		logic [CW-1:0] fx_sat;
		logic [CW-1:0] fy_sat;
		logic          dneg;
		logic          deg;
	} tail_t;

	function automatic logic [MW-1:0] mag_diff(input logic [DW-1:0] v);
		logic [DW-1:0] n;
		n = -v;
		return v[DW-1] ? n[MW-1:0] : v[MW-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/point_line_projection_core.sv
// top level of the point-line projection core
// depends on plp_pkg, plp_front, plp_div and plp_sqrt
`timescale 1ns / 1ps
`default_nettype none

// Projects point P onto the line through A and B, all signed q24.8, and gives
// the foot D, the signed length A to D and the distance P to D, each saturated,
// plus a flag when A equals B (then D = A, along 0, distance |PA|). An item is
// taken on any clock edge with start high; busy is always low, so a new item may
// enter every cycle. Every item comes back on the result ports for one cycle with
// done high and in order, after passing every stage below. There is no way to
// hold results off, so the receiver must take done whenever it appears. The
// latency is set by the pipeline: five front stages (differences, 32x32 products,
// dot product, split products, dividends), 34 divider stages (one quotient bit
// each), two stages forming the foot and the error vector, and 35 stages for the
// two length units (squares, sum, 32 root bits, rounding).
module point_line_projection_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [plp_pkg::CW-1:0]    point_x,
	input  wire logic [plp_pkg::CW-1:0]    point_y,
	input  wire logic [plp_pkg::CW-1:0]    start_x,
	input  wire logic [plp_pkg::CW-1:0]    start_y,
	input  wire logic [plp_pkg::CW-1:0]    end_x,
	input  wire logic [plp_pkg::CW-1:0]    end_y,
	output logic                           done,
	output logic [plp_pkg::CW-1:0]         foot_x,
	output logic [plp_pkg::CW-1:0]         foot_y,
	output logic [plp_pkg::CW-1:0]         along_signed,
	output logic [plp_pkg::LEN_W-1:0]      perp_distance,
	output logic                           degenerate
);

	localparam int CW  = plp_pkg::CW;
	localparam int QW  = plp_pkg::QUO_W;
	localparam int ADW = plp_pkg::ADW;
	localparam int FW  = plp_pkg::FW;
	localparam int EW  = plp_pkg::EW;
	localparam int LAT = plp_pkg::TOTAL_LAT;
	localparam int DL  = plp_pkg::DIV_LAT;
	localparam int SL  = plp_pkg::SQ_LAT;

	// item valid bits, one per pipeline register stage
	logic [LAT-1:0] vld_q;

	plp_pkg::front_t fo;
	logic [QW-1:0]   quo_x, quo_y;

	// side fields in lockstep with the divider stages
	plp_pkg::side_t side_s [DL];

	// foot stage
	logic [ADW-1:0] adx_p1, ady_p1;
	logic [FW-1:0]  fx_p1, fy_p1;
	logic [CW-1:0]  px_p1, py_p1;
	logic           dneg_p1, deg_p1;

	// error vector stage
	logic [EW-1:0]  ex_p2, ey_p2, adx_p2, ady_p2;
	plp_pkg::tail_t tail_p2;

	// side fields in lockstep with the length units
	plp_pkg::tail_t tail_s [SL];

	logic [plp_pkg::LEN_W-1:0] along_len, perp_len;
	logic [ADW-1:0] adx_d, ady_d;
	logic [ADW-1:0] qx_ext, qy_ext;
	logic [CW-1:0]  along_mag;

	// the receiver cannot stall, so the pipeline never does either
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	plp_front u_front (
		.clk     (clk),
		.point_x (point_x),
		.point_y (point_y),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.fo      (fo)
	);

	plp_div u_div_x (
		.clk  (clk),
		.num  (fo.num_x),
		.dsor (fo.dsor),
		.quo  (quo_x)
	);

	plp_div u_div_y (
		.clk  (clk),
		.num  (fo.num_y),
		.dsor (fo.dsor),
		.quo  (quo_y)
	);

	genvar k;
	generate
		for (k = 0; k < DL; k++) begin : g_side
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					side_s[k] <= fo.side;
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	// signed AD components; a degenerate line gives no offset at all
	always_comb begin
		qx_ext = ADW'(quo_x);
		qy_ext = ADW'(quo_y);
		if (side_s[DL-1].deg) begin
			adx_d = '0;
			ady_d = '0;
		end else begin
			adx_d = side_s[DL-1].negx ? -qx_ext : qx_ext;
			ady_d = side_s[DL-1].negy ? -qy_ext : qy_ext;
		end
	end

	always_ff @(posedge clk) begin
		adx_p1  <= adx_d;
		ady_p1  <= ady_d;
		fx_p1   <= {{(FW-CW){side_s[DL-1].ax[CW-1]}}, side_s[DL-1].ax} + {adx_d[ADW-1], adx_d};
		fy_p1   <= {{(FW-CW){side_s[DL-1].ay[CW-1]}}, side_s[DL-1].ay} + {ady_d[ADW-1], ady_d};
		px_p1   <= side_s[DL-1].px;
		py_p1   <= side_s[DL-1].py;
		dneg_p1 <= side_s[DL-1].dneg;
		deg_p1  <= side_s[DL-1].deg;
	end

	// clamp a foot coordinate to the 32-bit range
	function automatic logic [CW-1:0] sat_foot(input logic [FW-1:0] v);
		logic fits;
		fits = (v[FW-1:CW-1] == '0) || (v[FW-1:CW-1] == '1);
		if (fits) begin
			return v[CW-1:0];
		end
		return v[FW-1] ? plp_pkg::NEG_MIN : plp_pkg::POS_MAX;
	endfunction

	// distance is measured to the foot before it is clamped
	always_ff @(posedge clk) begin
		ex_p2          <= {{(EW-CW){px_p1[CW-1]}}, px_p1} - {fx_p1[FW-1], fx_p1};
		ey_p2          <= {{(EW-CW){py_p1[CW-1]}}, py_p1} - {fy_p1[FW-1], fy_p1};
		adx_p2         <= {{(EW-ADW){adx_p1[ADW-1]}}, adx_p1};
		ady_p2         <= {{(EW-ADW){ady_p1[ADW-1]}}, ady_p1};
		tail_p2.fx_sat <= sat_foot(fx_p1);
		tail_p2.fy_sat <= sat_foot(fy_p1);
		tail_p2.dneg   <= dneg_p1;
		tail_p2.deg    <= deg_p1;
	end

	plp_sqrt u_len_along (
		.clk (clk),
		.vx  (adx_p2),
		.vy  (ady_p2),
		.len (along_len)
	);

	plp_sqrt u_len_perp (
		.clk (clk),
		.vx  (ex_p2),
		.vy  (ey_p2),
		.len (perp_len)
	);

	generate
		for (k = 0; k < SL; k++) begin : g_tail
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					tail_s[k] <= tail_p2;
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					tail_s[k] <= tail_s[k-1];
				end
			end
		end
	endgenerate

	// along takes the sign of the dot product
	always_comb begin
		along_mag     = {1'b0, along_len};
		along_signed  = tail_s[SL-1].dneg ? -along_mag : along_mag;
		foot_x        = tail_s[SL-1].fx_sat;
		foot_y        = tail_s[SL-1].fy_sat;
		perp_distance = perp_len;
		degenerate    = tail_s[SL-1].deg;
		done          = vld_q[LAT-1];
	end

`ifndef SYNTHESIS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(plp_pkg::TOTAL_LAT) done)
		else $error("item did not come out after the pipeline latency");

	a_no_phantom : assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(plp_pkg::TOTAL_LAT) !done)
		else $error("result without a matching item");

	a_degenerate_along : assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (along_signed == '0))
		else $error("degenerate line with nonzero along length");
`endif

endmodule

`default_nettype wire

### rtl/core/plp_front.sv
// front end: differences, products, dot product, squared length and dividends
// depends on plp_pkg
`timescale 1ns / 1ps
`default_nettype none

module plp_front (
	input  wire logic                   clk,
	input  wire logic [plp_pkg::CW-1:0] point_x,
	input  wire logic [plp_pkg::CW-1:0] point_y,
	input  wire logic [plp_pkg::CW-1:0] start_x,
	input  wire logic [plp_pkg::CW-1:0] start_y,
	input  wire logic [plp_pkg::CW-1:0] end_x,
	input  wire logic [plp_pkg::CW-1:0] end_y,
	output plp_pkg::front_t             fo
);

	localparam int CW = plp_pkg::CW;
	localparam int DW = plp_pkg::DW;
	localparam int MW = plp_pkg::MW;
	localparam int PW = plp_pkg::PW;
	localparam int LW = plp_pkg::LW;
	localparam int NUM_W = plp_pkg::NUM_W;
	localparam int HW = LW - MW;
	localparam int PHW = HW + MW;
	localparam int PRW = PHW + MW;

	// stage 1
	logic [DW-1:0] apx_s1, apy_s1, abx_s1, aby_s1;
	logic [CW-1:0] px_s1, py_s1, ax_s1, ay_s1;
	// stage 2
	logic [PW-1:0] m1_s2, m2_s2, sqx_s2, sqy_s2;
	logic [MW-1:0] mabx_s2, maby_s2;
	logic          n1_s2, n2_s2, sabx_s2, saby_s2;
	logic [CW-1:0] px_s2, py_s2, ax_s2, ay_s2;
	// stage 3
	logic [LW-1:0] dot_s3, l2_s3;
	logic          dneg_s3;
	logic [MW-1:0] mabx_s3, maby_s3;
	logic          sabx_s3, saby_s3;
	logic [CW-1:0] px_s3, py_s3, ax_s3, ay_s3;
	// stage 4
	logic [PW-1:0]  plox_s4, ploy_s4;
	logic [PHW-1:0] phix_s4, phiy_s4;
	logic [LW-1:0]  l2_s4;
	logic           dneg_s4, negx_s4, negy_s4, deg_s4;
	logic [CW-1:0]  px_s4, py_s4, ax_s4, ay_s4;
	// stage 5
	plp_pkg::front_t fo_s5;

	logic [DW-1:0] apx_d, apy_d, abx_d, aby_d;
	logic [MW-1:0] mpx, mpy, mbx, mby;
	logic [LW-1:0] dot_d;
	logic          dneg_d;
	logic [PRW-1:0] prodx, prody;

	always_comb begin
		apx_d = {point_x[CW-1], point_x} - {start_x[CW-1], start_x};
		apy_d = {point_y[CW-1], point_y} - {start_y[CW-1], start_y};
		abx_d = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
		aby_d = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
	end

	always_ff @(posedge clk) begin
		apx_s1 <= apx_d;
		apy_s1 <= apy_d;
		abx_s1 <= abx_d;
		aby_s1 <= aby_d;
		px_s1  <= point_x;
		py_s1  <= point_y;
		ax_s1  <= start_x;
		ay_s1  <= start_y;
	end

	always_comb begin
		mpx = plp_pkg::mag_diff(apx_s1);
		mpy = plp_pkg::mag_diff(apy_s1);
		mbx = plp_pkg::mag_diff(abx_s1);
		mby = plp_pkg::mag_diff(aby_s1);
	end

	always_ff @(posedge clk) begin
		m1_s2   <= PW'(mpx) * PW'(mbx);
		m2_s2   <= PW'(mpy) * PW'(mby);
		sqx_s2  <= PW'(mbx) * PW'(mbx);
		sqy_s2  <= PW'(mby) * PW'(mby);
		mabx_s2 <= mbx;
		maby_s2 <= mby;
		n1_s2   <= apx_s1[DW-1] ^ abx_s1[DW-1];
		n2_s2   <= apy_s1[DW-1] ^ aby_s1[DW-1];
		sabx_s2 <= abx_s1[DW-1];
		saby_s2 <= aby_s1[DW-1];
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
	end

	// signed dot product from the two magnitude products
	always_comb begin
		if (n1_s2 == n2_s2) begin
			dot_d  = LW'(m1_s2) + LW'(m2_s2);
			dneg_d = n1_s2;
		end else if (m1_s2 >= m2_s2) begin
			dot_d  = LW'(m1_s2) - LW'(m2_s2);
			dneg_d = n1_s2;
		end else begin
			dot_d  = LW'(m2_s2) - LW'(m1_s2);
			dneg_d = n2_s2;
		end
		if (dot_d == '0) begin
			dneg_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		dot_s3  <= dot_d;
		dneg_s3 <= dneg_d;
		l2_s3   <= LW'(sqx_s2) + LW'(sqy_s2);
		mabx_s3 <= mabx_s2;
		maby_s3 <= maby_s2;
		sabx_s3 <= sabx_s2;
		saby_s3 <= saby_s2;
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
	end

	// dot times |ab| split into a low and a high partial product
	always_ff @(posedge clk) begin
		plox_s4 <= PW'(dot_s3[MW-1:0]) * PW'(mabx_s3);
		ploy_s4 <= PW'(dot_s3[MW-1:0]) * PW'(maby_s3);
		phix_s4 <= PHW'(dot_s3[LW-1:MW]) * PHW'(mabx_s3);
		phiy_s4 <= PHW'(dot_s3[LW-1:MW]) * PHW'(maby_s3);
		l2_s4   <= l2_s3;
		dneg_s4 <= dneg_s3;
		negx_s4 <= sabx_s3 ^ dneg_s3;
		negy_s4 <= saby_s3 ^ dneg_s3;
		deg_s4  <= (l2_s3 == '0);
		px_s4   <= px_s3;
		py_s4   <= py_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
	end

	// dividend 2*dot*|ab| + l2 gives the quotient rounded half away from zero
	always_comb begin
		prodx = {phix_s4, {MW{1'b0}}} + PRW'(plox_s4);
		prody = {phiy_s4, {MW{1'b0}}} + PRW'(ploy_s4);
	end

	always_ff @(posedge clk) begin
		fo_s5.num_x     <= NUM_W'({prodx, 1'b0}) + NUM_W'(l2_s4);
		fo_s5.num_y     <= NUM_W'({prody, 1'b0}) + NUM_W'(l2_s4);
		fo_s5.dsor      <= {l2_s4, 1'b0};
		fo_s5.side.px   <= px_s4;
		fo_s5.side.py   <= py_s4;
		fo_s5.side.ax   <= ax_s4;
		fo_s5.side.ay   <= ay_s4;
		fo_s5.side.dneg <= dneg_s4;
		fo_s5.side.negx <= negx_s4;
		fo_s5.side.negy <= negy_s4;
		fo_s5.side.deg  <= deg_s4;
	end

	assign fo = fo_s5;

endmodule

`default_nettype wire

### rtl/core/plp_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on plp_pkg
`timescale 1ns / 1ps
`default_nettype none

module plp_div (
	input  wire logic                       clk,
	input  wire logic [plp_pkg::NUM_W-1:0]  num,
	input  wire logic [plp_pkg::DSOR_W-1:0] dsor,
	output logic      [plp_pkg::QUO_W-1:0]  quo
);

	localparam int QW = plp_pkg::QUO_W;
	localparam int NW = plp_pkg::NUM_W;
	localparam int DSW = plp_pkg::DSOR_W;
	localparam int RW = plp_pkg::REM_W;

	logic [RW-1:0]  rem_s  [QW];
	logic [QW-1:0]  low_s  [QW];
	logic [QW-1:0]  quo_s  [QW];
	logic [DSW-1:0] dsor_s [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic [RW-1:0]  rem_in;
			logic [QW-1:0]  low_in;
			logic [QW-1:0]  quo_in;
			logic [DSW-1:0] dsor_in;
			logic [RW-1:0]  trial;
			logic           take;

			if (k == 0) begin : g_first
				// top bits of the dividend already sit below the divisor
				assign rem_in  = RW'(num[NW-1:QW]);
				assign low_in  = num[QW-1:0];
				assign quo_in  = '0;
				assign dsor_in = dsor;
			end else begin : g_next
				assign rem_in  = rem_s[k-1];
				assign low_in  = low_s[k-1];
				assign quo_in  = quo_s[k-1];
				assign dsor_in = dsor_s[k-1];
			end

			always_comb begin
				trial = {rem_in[RW-2:0], low_in[QW-1]};
				take  = (trial >= RW'(dsor_in));
			end

			always_ff @(posedge clk) begin
				rem_s[k]  <= take ? trial - RW'(dsor_in) : trial;
				low_s[k]  <= {low_in[QW-2:0], 1'b0};
				quo_s[k]  <= {quo_in[QW-2:0], take};
				dsor_s[k] <= dsor_in;
			end
		end
	endgenerate

	assign quo = quo_s[QW-1];

endmodule

`default_nettype wire

### rtl/core/plp_sqrt.sv
// pipelined rounded vector length, one root bit per stage, saturated
// depends on plp_pkg
`timescale 1ns / 1ps
`default_nettype none

module plp_sqrt (
	input  wire logic                      clk,
	input  wire logic [plp_pkg::EW-1:0]    vx,
	input  wire logic [plp_pkg::EW-1:0]    vy,
	output logic      [plp_pkg::LEN_W-1:0] len
);

	localparam int EW = plp_pkg::EW;
	localparam int LNW = plp_pkg::LEN_W;
	localparam int RW = plp_pkg::SQ_R_W;
	localparam int NIT = plp_pkg::SQ_ITER;
	localparam int SQW = 2 * LNW;

	logic [SQW-1:0] sqx_s1, sqy_s1;
	logic           big_s1;
	logic [RW-1:0]  s_s2;
	logic           big_s2;
	logic [RW-1:0]  s_it [NIT];
	logic [RW-1:0]  r_it [NIT];
	logic           big_it [NIT];
	logic [LNW-1:0] len_s3;

	logic [EW-1:0] nx, ny, mx, my;
	logic [RW-1:0] r_fin;

	always_comb begin
		nx = -vx;
		ny = -vy;
		mx = vx[EW-1] ? nx : vx;
		my = vy[EW-1] ? ny : vy;
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= SQW'(mx[LNW-1:0]) * SQW'(mx[LNW-1:0]);
		sqy_s1 <= SQW'(my[LNW-1:0]) * SQW'(my[LNW-1:0]);
		big_s1 <= (mx > EW'(plp_pkg::LEN_MAX)) || (my > EW'(plp_pkg::LEN_MAX));
	end

	always_ff @(posedge clk) begin
		s_s2   <= RW'(sqx_s1) + RW'(sqy_s1);
		big_s2 <= big_s1;
	end

	genvar k;
	generate
		for (k = 0; k < NIT; k++) begin : g_step
			localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NIT - 1) - 2 * k);
			logic [RW-1:0] s_in, r_in, t;
			logic          big_in;

			if (k == 0) begin : g_first
				assign s_in   = s_s2;
				assign r_in   = '0;
				assign big_in = big_s2;
			end else begin : g_next
				assign s_in   = s_it[k-1];
				assign r_in   = r_it[k-1];
				assign big_in = big_it[k-1];
			end

			assign t = r_in + BIT;

			always_ff @(posedge clk) begin
				if (s_in >= t) begin
					s_it[k] <= s_in - t;
					r_it[k] <= (r_in >> 1) + BIT;
				end else begin
					s_it[k] <= s_in;
					r_it[k] <= r_in >> 1;
				end
				big_it[k] <= big_in;
			end
		end
	endgenerate

	// round to nearest from the remainder, then clamp
	always_comb begin
		r_fin = (s_it[NIT-1] > r_it[NIT-1]) ? r_it[NIT-1] + RW'(1) : r_it[NIT-1];
	end

	always_ff @(posedge clk) begin
		if (big_it[NIT-1] || (r_fin > RW'(plp_pkg::LEN_MAX))) begin
			len_s3 <= plp_pkg::LEN_MAX;
		end else begin
			len_s3 <= r_fin[LNW-1:0];
		end
	end

	assign len = len_s3;

endmodule

`default_nettype wire

### sim/tb_point_line_projection_core.sv
// self-checking testbench for point_line_projection_core
// depends on plp_pkg and the rtl of the core; stands alone otherwise
`timescale 1ns / 1ps

module tb_point_line_projection_core;

	localparam int CW    = plp_pkg::CW;
	localparam int LEN_W = plp_pkg::LEN_W;
	localparam logic [CW-1:0]    POS_MAX = plp_pkg::POS_MAX;
	localparam logic [CW-1:0]    NEG_MIN = plp_pkg::NEG_MIN;
	localparam logic [LEN_W-1:0] LEN_MAX = plp_pkg::LEN_MAX;

	localparam int N_RANDOM    = 1930;
	localparam int N_STEADY    = 250;        // last items, sent back to back
	localparam int DRAIN_WAIT  = plp_pkg::TOTAL_LAT + 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint LEN_SAT = 64'sd2147483647;

	// one expected or observed result
	typedef struct {
		logic [CW-1:0]    fx;
		logic [CW-1:0]    fy;
		logic [CW-1:0]    along;
		logic [LEN_W-1:0] perp;
		logic             deg;
	} proj_t;

	// one directed row: p, a, b and an optional typed-in answer
	typedef struct {
		logic [CW-1:0] v [6];
		bit            typed;
		proj_t         ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CW-1:0] point_x = '0, point_y = '0, start_x = '0, start_y = '0;
	logic [CW-1:0] end_x = '0, end_y = '0;
	logic done;
	logic [CW-1:0] foot_x, foot_y, along_signed;
	logic [LEN_W-1:0] perp_distance;
	logic degenerate;

	// typed-in answer that travels with the item on the ports
	bit    typed_now = 1'b0;
	proj_t typed_ans;

	proj_t pending_q [$];
	int    errors = 0;
	int    cycles = 0;
	row_t  rows [$];

	point_line_projection_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.done         (done),
		.foot_x       (foot_x),
		.foot_y       (foot_y),
		.along_signed (along_signed),
		.perp_distance(perp_distance),
		.degenerate   (degenerate)
	);

	always #1 clk = ~clk;

	// rounded length of (x, y), ties away from zero, saturated
	function automatic longint round_len(longint x, longint y);
		longint mx, my;
		logic [127:0] s, r, t;
		mx = x < 0 ? -x : x;
		my = y < 0 ? -y : y;
		if (mx > LEN_SAT || my > LEN_SAT) begin
			return LEN_SAT;
		end
		s = mx * mx + my * my;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= s)
				r = t;
		end
		if (s - r * r > r)
			r = r + 1;
		return (r > LEN_SAT) ? LEN_SAT : longint'(r);
	endfunction

	// one component of the offset a to d: ab * dot / |ab|^2, rounded
	function automatic longint offset_comp(longint ab, logic [129:0] dmag, bit dneg,
			logic [129:0] l2);
		logic [129:0] mab, q;
		mab = ab < 0 ? -ab : ab;
		q = (2 * dmag * mab + l2) / (2 * l2);
		return ((ab < 0) != dneg) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [CW-1:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return POS_MAX;
		if (v < -64'sd2147483648)
			return NEG_MIN;
		return v[CW-1:0];
	endfunction

	// exact projection of p onto the line through a and b
	function automatic proj_t project(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
			logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
			logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
		proj_t o;
		logic signed [129:0] apx, apy, abx, aby, dot, l2s;
		logic [129:0] dmag, l2;
		bit dneg;
		longint adx, ady, fx, fy, along;
		apx = px - ax;
		apx = longint'(px) - longint'(ax);
		apy = longint'(py) - longint'(ay);
		abx = longint'(bx) - longint'(ax);
		aby = longint'(by) - longint'(ay);
		dot = apx * abx + apy * aby;
		l2s = abx * abx + aby * aby;
		l2 = l2s;
		dneg = dot < 0;
		dmag = dneg ? -dot : dot;
		adx = 0;
		ady = 0;
		o.deg = (l2 == 0);
		if (!o.deg) begin
			adx = offset_comp(longint'(abx), dmag, dneg, l2);
			ady = offset_comp(longint'(aby), dmag, dneg, l2);
		end
		fx = longint'(ax) + adx;
		fy = longint'(ay) + ady;
		along = round_len(adx, ady);
		if (dneg)
			along = -along;
		// distance uses the foot before clamping
		o.perp = LEN_W'(round_len(longint'(px) - fx, longint'(py) - fy));
		o.fx = clamp32(fx);
		o.fy = clamp32(fy);
		o.along = along[CW-1:0];
		return o;
	endfunction

	// coordinate with a mix of spans so small, mid and full range all appear
	function automatic logic [CW-1:0] rand_coord(int span);
		case (span)
			0: begin
				return $urandom;
			end
			1: begin
				return 32'($signed($urandom_range(0, 8192)) - 4096);
			end
			default: begin
				return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
			end
		endcase
	endfunction

	task automatic add_row(logic [CW-1:0] a0, logic [CW-1:0] a1, logic [CW-1:0] a2,
			logic [CW-1:0] a3, logic [CW-1:0] a4, logic [CW-1:0] a5);
		row_t r;
		r.v = '{a0, a1, a2, a3, a4, a5};
		r.typed = 1'b0;
		rows.push_back(r);
	endtask

	// typed-in answer attached to the last row
	task automatic set_answer(logic [CW-1:0] fx, logic [CW-1:0] fy, logic [CW-1:0] al,
			logic [LEN_W-1:0] pd, logic dg);
		rows[$].typed = 1'b1;
		rows[$].ans = '{fx, fy, al, pd, dg};
	endtask

	task automatic send(logic [CW-1:0] v [6], bit typed, proj_t ans, bit allow_gap);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		point_x <= v[0];
		point_y <= v[1];
		start_x <= v[2];
		start_y <= v[3];
		end_x <= v[4];
		end_y <= v[5];
		typed_now <= typed;
		typed_ans <= ans;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// acceptance and checking, all sampled at the rising edge
	always @(posedge clk) begin
		proj_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result foot=(%0d,%0d)", $time,
					$signed(foot_x), $signed(foot_y));
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (foot_x !== want.fx) begin
					$display("%0t: foot_x exp %0d got %0d", $time, $signed(want.fx),
						$signed(foot_x));
					errors++;
				end
				if (foot_y !== want.fy) begin
					$display("%0t: foot_y exp %0d got %0d", $time, $signed(want.fy),
						$signed(foot_y));
					errors++;
				end
				if (along_signed !== want.along) begin
					$display("%0t: along_signed exp %0d got %0d", $time,
						$signed(want.along), $signed(along_signed));
					errors++;
				end
				if (perp_distance !== want.perp) begin
					$display("%0t: perp_distance exp %0d got %0d", $time, want.perp,
						perp_distance);
					errors++;
				end
				if (degenerate !== want.deg) begin
					$display("%0t: degenerate exp %0b got %0b", $time, want.deg,
						degenerate);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			if (typed_now)
				pending_q.push_back(typed_ans);
			else
				pending_q.push_back(project(point_x, point_y, start_x, start_y,
					end_x, end_y));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [CW-1:0] v [6];
		proj_t none;
		int span;
		int kind;
		none = '{'0, '0, '0, '0, 1'b0};

		// directed rows: p, a, b
		add_row(0, 0, 0, 0, 0, 0);
		set_answer(0, 0, 0, 0, 1'b1);
		add_row(768, 1024, 0, 0, 0, 0);
		set_answer(0, 0, 0, 1280, 1'b1);
		add_row(POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
		set_answer(NEG_MIN, NEG_MIN, 0, LEN_MAX, 1'b1);
		add_row(NEG_MIN, POS_MAX, 5, 7, 5, 7);
		add_row(1280, 768, 0, 0, 2560, 0);
		add_row(-1280, 768, 0, 0, 2560, 0);
		add_row(0, 2560, 0, 0, 2560, 0);
		add_row(0, 1, 0, 0, 32'h4000_0000, 1);
		add_row(1, 0, 0, 0, 32'h4000_0000, 32'h4000_0000);
		add_row(NEG_MIN, POS_MAX, POS_MAX, NEG_MIN, POS_MAX - 256, NEG_MIN + 256);
		add_row(POS_MAX, POS_MAX, 0, 0, 256, 256);
		add_row(NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN);
		add_row(POS_MAX, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX, NEG_MIN);
		add_row(POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, POS_MAX, NEG_MIN);
		add_row(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, POS_MAX, POS_MAX);
		add_row(32'hffff_ffff, 32'hffff_ffff, 0, 0, 1, 0);
		add_row(300, -200, 100, 100, -900, 400);
		add_row(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 0, 0);

		// reset held low, then released
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].v, rows[i].typed, rows[i].ans, 1'b1);

		for (int n = 0; n < N_RANDOM; n++) begin
			span = $urandom_range(0, 2);
			kind = $urandom_range(0, 9);
			foreach (v[k])
				v[k] = rand_coord(span);
			if (kind == 0) begin
				// a equals b
				v[4] = v[2];
				v[5] = v[3];
			end else if (kind == 1) begin
				// p on the line, or a multiple of ab away
				v[0] = v[2] + 2 * (v[4] - v[2]);
				v[1] = v[3] + 2 * (v[5] - v[3]);
			end else if (kind == 2) begin
				// p square to ab at a, so the dot product is zero
				v[0] = v[2] - (v[5] - v[3]);
				v[1] = v[3] + (v[4] - v[2]);
			end
			if (n == N_RANDOM / 2) begin
				// hold off until the pipe is empty
				start <= 1'b0;
				@(posedge clk);
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			send(v, 1'b0, none, n < N_RANDOM - N_STEADY);
		end
		start <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/core/plp_pkg.sv
rtl/core/plp_front.sv
rtl/core/plp_div.sv
rtl/core/plp_sqrt.sv
rtl/core/point_line_projection_core.sv
sim/tb_point_line_projection_core.sv
